// ===== sv/intel_hex_record_parser_core_assert.svh =====
// Assertion macros for the Intel HEX record parser checker.
// Depends on nothing; included by the checker file.
`ifndef INTEL_HEX_RECORD_PARSER_CORE_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define IHEX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define IHEX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ihex_pkg.sv =====
// Shared types, codes and constants of the Intel HEX record parser.
// Depends on nothing; used by every module of the block but ihex_ram.
`default_nettype none

package ihex_pkg;

   localparam int MAX_DATA_BYTES_DEFAULT = 32;

   localparam logic [7:0]  CHAR_COLON           = 8'h3A;
   localparam logic [7:0]  CHAR_NEWLINE         = 8'h0A;
   localparam logic [7:0]  CHAR_COUNT_MAX       = 8'hFF;
   localparam logic [7:0]  MIN_RECORD_CHARS     = 8'd11;
   localparam logic [7:0]  REC_DATA             = 8'h00;
   localparam logic [7:0]  REC_EOF              = 8'h01;
   localparam logic [7:0]  REC_EXT_LINEAR       = 8'h04;
   localparam logic [7:0]  EXT_ADDR_LEN         = 8'h02;
   localparam logic        ENFORCE_CHECKSUM_RST = 1'b1;
   localparam logic [31:0] WINDOW_LIMIT_RST     = 32'h0000_4000;

   localparam logic CSR_ENFORCE_CHECKSUM = 1'b0;
   localparam logic CSR_WINDOW_LIMIT     = 1'b1;

   typedef enum logic [2:0] {
      ST_DATA_OK     = 3'd0,
      ST_EXT_ADDR    = 3'd1,
      ST_EOF         = 3'd2,
      ST_UNSUPPORTED = 3'd3,
      ST_SHORT       = 3'd4,
      ST_MALFORMED   = 3'd5,
      ST_CSUM_BAD    = 3'd6,
      ST_TOO_LONG    = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREP,
      BK_WRITE,
      BK_EXT_LO,
      BK_EXT_HI,
      BK_STAT
   } back_state_type;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_file;
   } req_word_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [7:0]  data;
      logic [2:0]  status;
      logic        beyond_window;
      logic        last;
      logic        any_written;
      logic [31:0] lowest_address;
      logic [31:0] highest_address;
   } rsp_word_type;

   typedef struct packed {
      logic        bank;
      logic        eof;
      status_type  status;
      logic [7:0]  dat;
      logic [7:0]  len;
      logic [15:0] addr16;
   } line_desc_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } bank_release_type;

endpackage

`default_nettype wire

// ===== sv/ihex_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the line data banks of the parser.
`default_nettype none

module ihex_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 66
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/ihex_front.sv =====
// Character front end: parses hex text into a line header, fills a data bank
// and classifies each record at line end. Depends on ihex_pkg.
`default_nettype none

module ihex_front #(
   parameter int MAX_DATA_BYTES = ihex_pkg::MAX_DATA_BYTES_DEFAULT,
   parameter int BUF_DEPTH      = MAX_DATA_BYTES + 1,
   parameter int ADDR_W         = $clog2(2 * BUF_DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire ihex_pkg::req_word_type    req_word,
   input  wire logic                      enforce_checksum,
   input  wire ihex_pkg::bank_release_type release_bank,
   output logic                           wr_en,
   output logic [ADDR_W-1:0]              wr_addr,
   output logic [7:0]                     wr_data,
   output logic                           desc_push,
   output ihex_pkg::line_desc_type        desc
);

   localparam int IDX_W = $clog2(BUF_DEPTH);

   logic [7:0]  char_count_ff, char_count_in;
   logic [4:0]  pending_ff, pending_in;
   logic [1:0]  line_bad_ff, line_bad_in;
   logic [7:0]  byte_sum_ff, byte_sum_in;
   logic [31:0] header_ff, header_in;
   logic [1:0]  busy_ff, busy_in;
   logic        wr_bank_ff, wr_bank_in;

   logic        accept;
   logic        line_end;
   logic [4:0]  nib;
   logic [7:0]  byte_val;
   logic [7:0]  count_m1;
   logic [6:0]  pair_idx;
   logic [6:0]  slot;
   logic [IDX_W-1:0] slot_idx;
   logic [7:0]  len;
   logic [7:0]  rec_type;
   logic [9:0]  expect_count;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         d = c - 8'h30;
         return {1'b1, d[3:0]};
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         d = c - 8'h57;
         return {1'b1, d[3:0]};
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         d = c - 8'h37;
         return {1'b1, d[3:0]};
      end
      return 5'b0_0000;
   endfunction

   assign req_full = busy_ff[wr_bank_ff];
   assign accept   = req_push && !req_full;
   assign line_end = accept && ((req_word.character == ihex_pkg::CHAR_NEWLINE) ||
                                req_word.end_of_file);

   assign nib      = hex_nibble(req_word.character);
   assign byte_val = {pending_ff[3:0], nib[3:0]};
   assign count_m1 = char_count_ff - 8'd1;
   assign pair_idx = count_m1[7:1];
   assign slot     = pair_idx - 7'd4;
   assign slot_idx = slot[IDX_W-1:0];

   always_comb begin
      char_count_in = char_count_ff;
      pending_in    = pending_ff;
      line_bad_in   = line_bad_ff;
      byte_sum_in   = byte_sum_ff;
      header_in     = header_ff;
      wr_en         = 1'b0;
      if (accept && !is_blank(req_word.character) &&
          (char_count_ff != ihex_pkg::CHAR_COUNT_MAX)) begin
         char_count_in = char_count_ff + 8'd1;
         if (char_count_ff == 8'd0) begin
            if (req_word.character != ihex_pkg::CHAR_COLON) begin
               line_bad_in[0] = 1'b1;
            end
         end else begin
            if (!nib[4]) begin
               line_bad_in[1] = 1'b1;
            end
            if (!pending_ff[4]) begin
               pending_in = {1'b1, nib[3:0]};
            end else begin
               pending_in  = 5'b0_0000;
               byte_sum_in = byte_sum_ff + byte_val;
               if (pair_idx[6:2] == 5'd0) begin
                  header_in = {header_ff[23:0], byte_val};
               end else if (slot < 7'(BUF_DEPTH)) begin
                  wr_en = 1'b1;
               end
            end
         end
      end
   end

   assign wr_data = byte_val;
   assign wr_addr = wr_bank_ff ? ADDR_W'(BUF_DEPTH) + ADDR_W'(slot_idx) : ADDR_W'(slot_idx);

   assign len          = header_in[31:24];
   assign rec_type     = header_in[7:0];
   assign expect_count = 10'(ihex_pkg::MIN_RECORD_CHARS) + {1'b0, len, 1'b0};

   always_comb begin
      desc.bank   = wr_bank_ff;
      desc.eof    = req_word.end_of_file;
      desc.len    = len;
      desc.addr16 = header_in[23:8];
      desc.dat    = rec_type;
      desc.status = ihex_pkg::ST_UNSUPPORTED;
      if (char_count_in < ihex_pkg::MIN_RECORD_CHARS) begin
         desc.status = ihex_pkg::ST_SHORT;
         desc.dat    = 8'h00;
      end else if (line_bad_in != 2'b00) begin
         desc.status = ihex_pkg::ST_MALFORMED;
         desc.dat    = 8'h00;
      end else if (len > 8'(MAX_DATA_BYTES)) begin
         desc.status = ihex_pkg::ST_TOO_LONG;
      end else if ({2'b00, char_count_in} != expect_count) begin
         desc.status = ihex_pkg::ST_MALFORMED;
         desc.dat    = 8'h00;
      end else if (enforce_checksum && (byte_sum_in != 8'h00)) begin
         desc.status = ihex_pkg::ST_CSUM_BAD;
      end else if (rec_type == ihex_pkg::REC_DATA) begin
         desc.status = ihex_pkg::ST_DATA_OK;
      end else if (rec_type == ihex_pkg::REC_EXT_LINEAR) begin
         if (len != ihex_pkg::EXT_ADDR_LEN) begin
            desc.status = ihex_pkg::ST_MALFORMED;
            desc.dat    = 8'h00;
         end else begin
            desc.status = ihex_pkg::ST_EXT_ADDR;
         end
      end else if (rec_type == ihex_pkg::REC_EOF) begin
         desc.status = ihex_pkg::ST_EOF;
      end
   end

   assign desc_push = line_end;

   always_comb begin
      busy_in    = busy_ff;
      wr_bank_in = wr_bank_ff;
      if (release_bank.valid) begin
         busy_in[release_bank.bank] = 1'b0;
      end
      if (line_end) begin
         busy_in[wr_bank_ff] = 1'b1;
         wr_bank_in          = !wr_bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= 8'd0;
         pending_ff    <= 5'd0;
         line_bad_ff   <= 2'd0;
         byte_sum_ff   <= 8'd0;
         header_ff     <= 32'd0;
         busy_ff       <= 2'b00;
         wr_bank_ff    <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         wr_bank_ff <= wr_bank_in;
         if (line_end) begin
            char_count_ff <= 8'd0;
            pending_ff    <= 5'd0;
            line_bad_ff   <= 2'd0;
            byte_sum_ff   <= 8'd0;
            header_ff     <= 32'd0;
         end else begin
            char_count_ff <= char_count_in;
            pending_ff    <= pending_in;
            line_bad_ff   <= line_bad_in;
            byte_sum_ff   <= byte_sum_in;
            header_ff     <= header_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/ihex_desc_queue.sv =====
// Two-entry queue of classified line descriptors between front and back end.
// Depends on ihex_pkg.
`default_nettype none

module ihex_desc_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire ihex_pkg::line_desc_type push_desc,
   input  wire logic                    pop,
   output logic                         empty,
   output ihex_pkg::line_desc_type      head
);

   ihex_pkg::line_desc_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !(pop && !empty)) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop && !empty) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/ihex_back.sv =====
// Back end: carries out classified lines, emits byte writes and line status,
// keeps extended address and written bounds. Depends on ihex_pkg.
`default_nettype none

module ihex_back #(
   parameter int MAX_DATA_BYTES = ihex_pkg::MAX_DATA_BYTES_DEFAULT,
   parameter int BUF_DEPTH      = MAX_DATA_BYTES + 1,
   parameter int ADDR_W         = $clog2(2 * BUF_DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_empty,
   input  wire ihex_pkg::line_desc_type    q_head,
   output logic                            q_pop,
   input  wire logic [31:0]                window_limit,
   output logic [ADDR_W-1:0]               rd_addr,
   input  wire logic [7:0]                 rd_data,
   output ihex_pkg::bank_release_type      release_bank,
   input  wire logic                       rsp_pop,
   output logic                            rsp_empty,
   output ihex_pkg::rsp_word_type          rsp_word
);

   localparam int IDX_W = $clog2(BUF_DEPTH);

   ihex_pkg::back_state_type state_ff, state_in;
   ihex_pkg::line_desc_type  desc_ff;
   ihex_pkg::rsp_word_type   rsp_ff, rsp_in;

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] rd_idx;
   logic [31:0]      cur_addr_ff;
   logic [15:0]      ext_high_ff;
   logic [7:0]       ext_lo_ff;
   logic             bounds_valid_ff;
   logic [31:0]      min_ff, min_in;
   logic [31:0]      max_ff, max_in;
   logic             rsp_valid_ff;

   logic slot_free;
   logic emit_write;
   logic emit_stat;
   logic last_byte;
   logic has_work;

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign last_byte = ({{(8 - IDX_W){1'b0}}, idx_ff} == (desc_ff.len - 8'd1));
   assign has_work  = ((q_head.status == ihex_pkg::ST_DATA_OK) && (q_head.len != 8'd0)) ||
                      (q_head.status == ihex_pkg::ST_EXT_ADDR);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ihex_pkg::BK_IDLE: begin
            if (!q_empty) begin
               state_in = has_work ? ihex_pkg::BK_PREP : ihex_pkg::BK_STAT;
            end
         end
         ihex_pkg::BK_PREP: begin
            state_in = (desc_ff.status == ihex_pkg::ST_EXT_ADDR) ?
                       ihex_pkg::BK_EXT_LO : ihex_pkg::BK_WRITE;
         end
         ihex_pkg::BK_WRITE: begin
            if (slot_free && last_byte) begin
               state_in = ihex_pkg::BK_STAT;
            end
         end
         ihex_pkg::BK_EXT_LO: begin
            state_in = ihex_pkg::BK_EXT_HI;
         end
         ihex_pkg::BK_EXT_HI: begin
            state_in = ihex_pkg::BK_STAT;
         end
         ihex_pkg::BK_STAT: begin
            if (slot_free) begin
               state_in = ihex_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = ihex_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop      = 1'b0;
      emit_write = 1'b0;
      emit_stat  = 1'b0;
      rd_idx     = idx_ff;
      unique case (state_ff)
         ihex_pkg::BK_IDLE: begin
            q_pop = !q_empty;
         end
         ihex_pkg::BK_PREP: begin
            rd_idx = '0;
         end
         ihex_pkg::BK_WRITE: begin
            emit_write = slot_free;
            rd_idx     = slot_free ? idx_ff + IDX_W'(1) : idx_ff;
         end
         ihex_pkg::BK_EXT_LO: begin
            rd_idx = IDX_W'(1);
         end
         ihex_pkg::BK_EXT_HI: begin
            rd_idx = idx_ff;
         end
         ihex_pkg::BK_STAT: begin
            emit_stat = slot_free;
         end
         default: begin
            rd_idx = idx_ff;
         end
      endcase
   end

   assign rd_addr = desc_ff.bank ? ADDR_W'(BUF_DEPTH) + ADDR_W'(rd_idx) : ADDR_W'(rd_idx);

   assign release_bank.valid = emit_stat;
   assign release_bank.bank  = desc_ff.bank;

   assign min_in = (!bounds_valid_ff || (cur_addr_ff < min_ff)) ? cur_addr_ff : min_ff;
   assign max_in = (!bounds_valid_ff || (cur_addr_ff > max_ff)) ? cur_addr_ff : max_ff;

   always_comb begin
      rsp_in.kind            = 1'b1;
      rsp_in.address         = 32'd0;
      rsp_in.data            = desc_ff.dat;
      rsp_in.status          = desc_ff.status;
      rsp_in.beyond_window   = 1'b0;
      rsp_in.last            = 1'b1;
      rsp_in.any_written     = bounds_valid_ff;
      rsp_in.lowest_address  = min_ff;
      rsp_in.highest_address = max_ff;
      if (emit_write) begin
         rsp_in.kind            = 1'b0;
         rsp_in.address         = cur_addr_ff;
         rsp_in.data            = rd_data;
         rsp_in.status          = ihex_pkg::ST_DATA_OK;
         rsp_in.beyond_window   = (cur_addr_ff >= window_limit);
         rsp_in.last            = 1'b0;
         rsp_in.any_written     = 1'b1;
         rsp_in.lowest_address  = min_in;
         rsp_in.highest_address = max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         desc_ff <= q_head;
         idx_ff  <= '0;
      end else if (emit_write) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (state_ff == ihex_pkg::BK_PREP) begin
         cur_addr_ff <= {ext_high_ff, 16'h0000} + {16'h0000, desc_ff.addr16};
      end else if (emit_write) begin
         cur_addr_ff <= cur_addr_ff + 32'd1;
      end
      if (state_ff == ihex_pkg::BK_EXT_LO) begin
         ext_lo_ff <= rd_data;
      end
      if (emit_write || emit_stat) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ihex_pkg::BK_IDLE;
         ext_high_ff     <= 16'd0;
         bounds_valid_ff <= 1'b0;
         min_ff          <= 32'd0;
         max_ff          <= 32'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_write || emit_stat) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ihex_pkg::BK_EXT_HI) begin
            ext_high_ff <= {ext_lo_ff, rd_data};
         end
         if (emit_write) begin
            bounds_valid_ff <= 1'b1;
            min_ff          <= min_in;
            max_ff          <= max_in;
         end
         if (emit_stat && desc_ff.eof) begin
            ext_high_ff     <= 16'd0;
            bounds_valid_ff <= 1'b0;
            min_ff          <= 32'd0;
            max_ff          <= 32'd0;
         end
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/intel_hex_record_parser_core.sv =====
// Intel HEX record parser, top level: front end, descriptor queue, back end, data RAM.
// Characters are taken one per cycle while req_full is low; two line banks let the
// next line be parsed while the back end emits the previous one. A line's status
// word leaves after its byte writes, which leave one per cycle while the result slot is free.
// req_full rises only while both line banks wait on the back end.
// Synchronous active-high reset clears all control state and restores register defaults.
`default_nettype none

module intel_hex_record_parser_core #(
   parameter int MAX_DATA_BYTES = ihex_pkg::MAX_DATA_BYTES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire ihex_pkg::req_word_type req_word,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output ihex_pkg::rsp_word_type      rsp_word,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [31:0]            csr_wdata
);

   localparam int BUF_DEPTH = MAX_DATA_BYTES + 1;
   localparam int ADDR_W    = $clog2(2 * BUF_DEPTH);

   logic        enforce_checksum_ff;
   logic [31:0] window_limit_ff;

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [7:0]                 wr_data;
   logic [ADDR_W-1:0]          rd_addr;
   logic [7:0]                 rd_data;
   logic                       desc_push;
   ihex_pkg::line_desc_type    push_desc;
   ihex_pkg::line_desc_type    q_head;
   logic                       q_empty;
   logic                       q_pop;
   ihex_pkg::bank_release_type release_bank;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enforce_checksum_ff <= ihex_pkg::ENFORCE_CHECKSUM_RST;
         window_limit_ff     <= ihex_pkg::WINDOW_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ihex_pkg::CSR_ENFORCE_CHECKSUM: begin
               enforce_checksum_ff <= csr_wdata[0];
            end
            ihex_pkg::CSR_WINDOW_LIMIT: begin
               window_limit_ff <= csr_wdata;
            end
            default: begin
               window_limit_ff <= window_limit_ff;
            end
         endcase
      end
   end

   ihex_front #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES),
      .BUF_DEPTH      (BUF_DEPTH),
      .ADDR_W         (ADDR_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_word         (req_word),
      .enforce_checksum (enforce_checksum_ff),
      .release_bank     (release_bank),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .desc_push        (desc_push),
      .desc             (push_desc)
   );

   ihex_desc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   ihex_ram #(
      .WIDTH (8),
      .DEPTH (2 * BUF_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ihex_back #(
      .MAX_DATA_BYTES (MAX_DATA_BYTES),
      .BUF_DEPTH      (BUF_DEPTH),
      .ADDR_W         (ADDR_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .window_limit (window_limit_ff),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .release_bank (release_bank),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_word     (rsp_word)
   );

endmodule

`default_nettype wire

// ===== sv/ihex_checker.sv =====
// Port-level checker for the Intel HEX record parser, bound to the top level.
// Depends on ihex_pkg and intel_hex_record_parser_core_assert.svh.
`default_nettype none
`include "intel_hex_record_parser_core_assert.svh"

module ihex_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_full,
   input wire logic                   rsp_empty,
   input wire logic                   rsp_pop,
   input wire ihex_pkg::rsp_word_type rsp_word
);

   `IHEX_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full, "Reset did not leave the parser empty and ready.")

   `IHEX_ASSERT_NEXT(a_word_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_word), "A waiting result word changed before it was taken.")

   `IHEX_ASSERT_NOW(a_write_in_bounds, clock, reset, !rsp_empty && !rsp_word.kind, rsp_word.any_written && !rsp_word.last && (rsp_word.lowest_address <= rsp_word.address) && (rsp_word.address <= rsp_word.highest_address), "A byte write lies outside the reported bounds.")

   `IHEX_ASSERT_NOW(a_bounds_idle_zero, clock, reset, !rsp_empty && !rsp_word.any_written, (rsp_word.lowest_address == 32'd0) && (rsp_word.highest_address == 32'd0), "Bounds are nonzero while nothing has been written.")

endmodule

bind intel_hex_record_parser_core ihex_checker u_checker (.*);

`default_nettype wire

// ===== tb/intel_hex_record_parser_core_tb.sv =====
// Self-checking testbench of the Intel HEX record parser core.
// Feeds hex text one character per word, predicts every result word in a scoreboard
// class and checks it as it leaves. Depends on ihex_pkg and intel_hex_record_parser_core.
`timescale 1ns / 1ps

module intel_hex_record_parser_core_tb;
   import ihex_pkg::*;

   localparam int MAX_BYTES = MAX_DATA_BYTES_DEFAULT;
   localparam int IDLE_CYCLES = 60;
   localparam int REPORT_LIMIT = 10;
   localparam bit KIND_WRITE = 1'b0;
   localparam bit KIND_STATUS = 1'b1;

   typedef enum int {
      LINE_LF,
      LINE_CRLF,
      LINE_EOF,
      LINE_LF_EOF
   } line_end_type;

   typedef enum int {
      SHAPE_DATA,
      SHAPE_EXT,
      SHAPE_EOF_REC,
      SHAPE_UNSUPPORTED,
      SHAPE_BAD_SUM,
      SHAPE_BAD_CHAR,
      SHAPE_NO_COLON,
      SHAPE_BAD_LENGTH,
      SHAPE_TOO_LONG,
      SHAPE_NOISE
   } line_shape_type;

   class hex_parse_tracker;
      bit [7:0]     char_count;
      bit           nib_valid;
      bit [3:0]     nib;
      bit [1:0]     line_bad;
      bit [7:0]     byte_sum;
      bit [31:0]    header;
      bit [7:0]     buffer [MAX_BYTES + 1];
      bit [15:0]    ext_high;
      bit           bounds_valid;
      bit [31:0]    min_w;
      bit [31:0]    max_w;
      bit           enforce;
      bit [31:0]    window;
      rsp_word_type due_words [$];
      int           error_count;
      int           word_count;

      function new();
         enforce = ENFORCE_CHECKSUM_RST;
         window = WINDOW_LIMIT_RST;
      endfunction

      function void set_register(logic idx, logic [31:0] val);
         if (idx == CSR_ENFORCE_CHECKSUM) begin
            enforce = val[0];
         end else begin
            window = val;
         end
      endfunction

      function void queue_word(bit kind, bit [31:0] addr, bit [7:0] dat, status_type st,
                               bit beyond, bit last);
         rsp_word_type w;
         w.kind = kind;
         w.address = addr;
         w.data = dat;
         w.status = st;
         w.beyond_window = beyond;
         w.last = last;
         w.any_written = bounds_valid;
         w.lowest_address = min_w;
         w.highest_address = max_w;
         due_words.push_back(w);
         word_count++;
      endfunction

      function void consume(bit [7:0] c);
         bit [7:0] p;
         bit [3:0] v;
         bit [7:0] b;
         int       k;
         p = char_count;
         if (p == CHAR_COUNT_MAX) return;
         char_count = p + 8'd1;
         if (p == 8'd0) begin
            if (c != CHAR_COLON) line_bad[0] = 1'b1;
            return;
         end
         if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
         end else if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 8'd10);
         end else if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
         end else begin
            line_bad[1] = 1'b1;
            v = 4'd0;
         end
         if (!nib_valid) begin
            nib_valid = 1'b1;
            nib = v;
            return;
         end
         b = {nib, v};
         nib_valid = 1'b0;
         byte_sum = byte_sum + b;
         k = (int'(p) - 1) >> 1;
         if (k < 4) begin
            header = {header[23:0], b};
         end else if (k - 4 < MAX_BYTES + 1) begin
            buffer[k - 4] = b;
         end
      endfunction

      function void close_line();
         bit [7:0]   len;
         bit [15:0]  addr16;
         bit [7:0]   rtype;
         bit [7:0]   dat;
         bit [31:0]  a;
         status_type st;
         len = header[31:24];
         addr16 = header[23:8];
         rtype = header[7:0];
         dat = rtype;
         if (char_count < MIN_RECORD_CHARS) begin
            st = ST_SHORT;
            dat = 8'd0;
         end else if (line_bad != 2'd0) begin
            st = ST_MALFORMED;
            dat = 8'd0;
         end else if (int'(len) > MAX_BYTES) begin
            st = ST_TOO_LONG;
         end else if (int'(char_count) != int'(MIN_RECORD_CHARS) + 2 * int'(len)) begin
            st = ST_MALFORMED;
            dat = 8'd0;
         end else if (enforce && byte_sum != 8'd0) begin
            st = ST_CSUM_BAD;
         end else if (rtype == REC_DATA) begin
            for (int i = 0; i < int'(len); i++) begin
               a = {ext_high, 16'h0000} + {16'h0000, addr16} + 32'(i);
               if (!bounds_valid) begin
                  bounds_valid = 1'b1;
                  min_w = a;
                  max_w = a;
               end else begin
                  if (a < min_w) min_w = a;
                  if (a > max_w) max_w = a;
               end
               queue_word(KIND_WRITE, a, buffer[i], ST_DATA_OK, a >= window, 1'b0);
            end
            st = ST_DATA_OK;
         end else if (rtype == REC_EXT_LINEAR) begin
            if (len != EXT_ADDR_LEN) begin
               st = ST_MALFORMED;
               dat = 8'd0;
            end else begin
               ext_high = {buffer[0], buffer[1]};
               st = ST_EXT_ADDR;
            end
         end else if (rtype == REC_EOF) begin
            st = ST_EOF;
         end else begin
            st = ST_UNSUPPORTED;
         end
         queue_word(KIND_STATUS, 32'd0, dat, st, 1'b0, 1'b1);
         char_count = 8'd0;
         nib_valid = 1'b0;
         line_bad = 2'd0;
         byte_sum = 8'd0;
         header = 32'd0;
      endfunction

      function void take_char(req_word_type w);
         bit [7:0] c;
         c = w.character;
         if (!(c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) consume(c);
         if (c == CHAR_NEWLINE || w.end_of_file) close_line();
         if (w.end_of_file) begin
            ext_high = 16'd0;
            bounds_valid = 1'b0;
            min_w = 32'd0;
            max_w = 32'd0;
         end
      endfunction

      function string describe(rsp_word_type w);
         return $sformatf("kind=%0d addr=%h data=%h status=%0d beyond=%0d last=%0d any=%0d low=%h high=%h",
                          w.kind, w.address, w.data, w.status, w.beyond_window, w.last,
                          w.any_written, w.lowest_address, w.highest_address);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type exp;
         if (due_words.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) $display("Unexpected result word: %s", describe(got));
            return;
         end
         exp = due_words.pop_front();
         if (got.kind !== exp.kind || got.address !== exp.address || got.data !== exp.data ||
             got.status !== exp.status || got.beyond_window !== exp.beyond_window ||
             got.last !== exp.last || got.any_written !== exp.any_written ||
             got.lowest_address !== exp.lowest_address ||
             got.highest_address !== exp.highest_address) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("Result word mismatch at %0t", $realtime);
               $display("  expected %s", describe(exp));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_push;
   logic         req_full;
   req_word_type req_word;
   logic         rsp_empty;
   logic         rsp_pop;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_index;
   logic [31:0]  csr_wdata;

   hex_parse_tracker tracker;
   bit [7:0]         line_chars [$];
   bit [7:0]         line_sum;
   bit [7:0]         rec_data [256];
   int               burst_left;
   int               chars_sent;
   int               stall_left;
   int               stall_pct;
   int               mode_timer;

   intel_hex_record_parser_core #(
      .MAX_DATA_BYTES(MAX_BYTES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_pop <= 1'b0;
         stall_left--;
      end else begin
         rsp_pop <= 1'b1;
         if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
      end
      mode_timer++;
      if (mode_timer == 97) begin
         mode_timer = 0;
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 10;
            2: stall_pct = 40;
            default: stall_pct = 80;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) tracker.check_word(rsp_word);
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic push_char(bit [7:0] c, bit eof);
      req_word_type w;
      w.character = c;
      w.end_of_file = eof;
      @(negedge clock);
      if (burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 48);
      end
      req_push <= 1'b1;
      req_word <= w;
      burst_left--;
      @(posedge clock);
      while (req_full) @(posedge clock);
      tracker.take_char(w);
      chars_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (tracker.due_words.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic bit [7:0] hex_digit(bit [3:0] v);
      if (v < 4'd10) return 8'("0") + 8'(v);
      return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
   endfunction

   function automatic bit [7:0] odd_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(128, 255));
         1: return 8'("G") + 8'($urandom_range(0, 19));
         2: return 8'("g") + 8'($urandom_range(0, 19));
         default: return 8'($urandom_range(0, 8));
      endcase
   endfunction

   task automatic add_byte(bit [7:0] b);
      if ($urandom_range(0, 15) == 0) begin
         case ($urandom_range(0, 4))
            0: line_chars.push_back(8'd32);
            1: line_chars.push_back(8'd9);
            2: line_chars.push_back(8'd11);
            3: line_chars.push_back(8'd12);
            default: line_chars.push_back(8'd13);
         endcase
      end
      line_chars.push_back(hex_digit(b[7:4]));
      line_chars.push_back(hex_digit(b[3:0]));
      line_sum = line_sum + b;
   endtask

   task automatic random_payload();
      for (int i = 0; i < 256; i++) rec_data[i] = 8'($urandom);
   endtask

   task automatic build_record(int len, int n_data, bit [15:0] addr, bit [7:0] rtype,
                               bit bad_sum);
      bit [7:0] csum;
      line_chars.delete();
      line_sum = 8'd0;
      line_chars.push_back(CHAR_COLON);
      add_byte(8'(len));
      add_byte(addr[15:8]);
      add_byte(addr[7:0]);
      add_byte(rtype);
      for (int i = 0; i < n_data; i++) add_byte(rec_data[i]);
      csum = 8'd0 - line_sum;
      if (bad_sum) csum = csum ^ 8'($urandom_range(1, 255));
      add_byte(csum);
   endtask

   task automatic send_line(line_end_type ending);
      bit eof_last;
      int n;
      eof_last = 1'b0;
      case (ending)
         LINE_CRLF: begin
            line_chars.push_back(8'd13);
            line_chars.push_back(CHAR_NEWLINE);
         end
         LINE_LF_EOF: begin
            line_chars.push_back(CHAR_NEWLINE);
            eof_last = 1'b1;
         end
         LINE_EOF: begin
            if (line_chars.size() == 0) line_chars.push_back(8'd32);
            eof_last = 1'b1;
         end
         default: line_chars.push_back(CHAR_NEWLINE);
      endcase
      n = line_chars.size();
      for (int i = 0; i < n; i++) push_char(line_chars[i], eof_last && i == n - 1);
   endtask

   task automatic make_line(line_shape_type shape);
      int       len;
      int       n;
      bit [7:0] rtype;
      random_payload();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_BYTES) : $urandom_range(0, 8);
      case (shape)
         SHAPE_DATA: build_record(len, len, 16'($urandom), REC_DATA, 1'b0);
         SHAPE_EXT: begin
            if ($urandom_range(0, 3) == 0) begin
               rec_data[0] = 8'd0;
               rec_data[1] = 8'd0;
            end
            build_record(2, 2, 16'($urandom_range(0, 1) ? 0 : $urandom), REC_EXT_LINEAR, 1'b0);
         end
         SHAPE_EOF_REC: build_record(0, 0, 16'h0000, REC_EOF, 1'b0);
         SHAPE_UNSUPPORTED: begin
            rtype = 8'($urandom);
            while (rtype == REC_DATA || rtype == REC_EOF || rtype == REC_EXT_LINEAR) begin
               rtype = 8'($urandom);
            end
            build_record(len % 5, len % 5, 16'($urandom), rtype, 1'b0);
         end
         SHAPE_BAD_SUM: build_record(len, len, 16'($urandom), REC_DATA, 1'b1);
         SHAPE_BAD_CHAR: begin
            build_record(len, len, 16'($urandom), REC_DATA, 1'b0);
            line_chars[$urandom_range(1, line_chars.size() - 1)] = odd_char();
         end
         SHAPE_NO_COLON: begin
            build_record(len, len, 16'($urandom), REC_DATA, 1'b0);
            line_chars[0] = odd_char();
         end
         SHAPE_BAD_LENGTH: begin
            build_record(len, len, 16'($urandom), REC_DATA, 1'b0);
            line_chars.push_back(8'("0"));
            if ($urandom_range(0, 1)) line_chars.push_back(8'("0"));
         end
         SHAPE_TOO_LONG: begin
            build_record($urandom_range(MAX_BYTES + 1, 255), $urandom_range(0, 6),
                         16'($urandom), REC_DATA, 1'($urandom));
         end
         default: begin
            line_chars.delete();
            n = $urandom_range(0, 24);
            if ($urandom_range(0, 1)) line_chars.push_back(CHAR_COLON);
            for (int i = 0; i < n; i++) line_chars.push_back(8'($urandom));
         end
      endcase
   endtask

   function automatic line_shape_type pick_shape();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return SHAPE_DATA;
      if (r < 63) return SHAPE_EXT;
      if (r < 67) return SHAPE_EOF_REC;
      if (r < 72) return SHAPE_UNSUPPORTED;
      if (r < 79) return SHAPE_BAD_SUM;
      if (r < 84) return SHAPE_BAD_CHAR;
      if (r < 87) return SHAPE_NO_COLON;
      if (r < 91) return SHAPE_BAD_LENGTH;
      if (r < 95) return SHAPE_TOO_LONG;
      return SHAPE_NOISE;
   endfunction

   function automatic line_end_type pick_ending();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return LINE_LF;
      if (r < 88) return LINE_CRLF;
      if (r < 94) return LINE_EOF;
      return LINE_LF_EOF;
   endfunction

   initial begin
      int          phase_chars;
      int          rand_words;
      bit          enforce_val;
      logic [31:0] window_val;
      tracker = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_word = '0;
      rsp_pop = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_ENFORCE_CHECKSUM;
      csr_wdata = 32'd0;
      stall_pct = 20;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lines under the reset register values.
      line_chars.delete();
      send_line(LINE_LF);
      line_chars = '{CHAR_COLON, 8'("0"), 8'("0")};
      send_line(LINE_LF);
      random_payload();
      build_record(1, 1, 16'h0000, REC_DATA, 1'b0);
      send_line(LINE_LF);
      build_record(MAX_BYTES, MAX_BYTES, 16'h3FF0, REC_DATA, 1'b0);
      send_line(LINE_CRLF);
      build_record(0, 0, 16'hFFFF, REC_DATA, 1'b0);
      send_line(LINE_LF);
      rec_data[0] = 8'hFF;
      rec_data[1] = 8'hFF;
      build_record(2, 2, 16'h0000, REC_EXT_LINEAR, 1'b0);
      send_line(LINE_LF);
      random_payload();
      build_record(4, 4, 16'hFFFF, REC_DATA, 1'b0);
      send_line(LINE_LF);
      build_record(3, 3, 16'h0000, REC_EXT_LINEAR, 1'b0);
      send_line(LINE_LF);
      build_record(1, 1, 16'h0010, 8'h02, 1'b0);
      send_line(LINE_LF);
      build_record(0, 0, 16'h0000, 8'hFF, 1'b0);
      send_line(LINE_LF);
      for (int s = SHAPE_BAD_SUM; s <= SHAPE_NOISE; s++) begin
         make_line(line_shape_type'(s));
         send_line(LINE_LF);
      end
      // A line far past the buffer saturates the character count.
      build_record(MAX_BYTES, 140, 16'h0000, REC_DATA, 1'b0);
      send_line(LINE_LF);
      build_record(0, 0, 16'h0000, REC_EOF, 1'b0);
      send_line(LINE_LF_EOF);
      random_payload();
      build_record(3, 3, 16'h4000, REC_DATA, 1'b0);
      send_line(LINE_EOF);
      line_chars.delete();
      send_line(LINE_EOF);

      wait_idle();
      write_csr(CSR_ENFORCE_CHECKSUM, 32'd0);
      write_csr(CSR_WINDOW_LIMIT, 32'd0);
      make_line(SHAPE_BAD_SUM);
      send_line(LINE_LF);
      make_line(SHAPE_DATA);
      send_line(LINE_LF);
      make_line(SHAPE_TOO_LONG);
      send_line(LINE_LF);

      rand_words = tracker.word_count;
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               enforce_val = 1'b0;
               window_val = 32'hFFFF_FFFF;
            end
            1: begin
               enforce_val = 1'b1;
               window_val = 32'd0;
            end
            default: begin
               enforce_val = 1'($urandom);
               window_val = $urandom_range(0, 1) ? $urandom_range(0, 32'h0002_0000) : $urandom;
            end
         endcase
         write_csr(CSR_ENFORCE_CHECKSUM, {31'd0, enforce_val});
         write_csr(CSR_WINDOW_LIMIT, window_val);
         phase_chars = chars_sent;
         while (chars_sent - phase_chars < 70 ||
                (phase == 3 && tracker.word_count - rand_words < 60)) begin
            make_line(pick_shape());
            send_line(pick_ending());
         end
      end

      wait_idle();
      if (tracker.error_count == 0 && tracker.due_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
